// ===== rtl/tkst_pkg.sv =====
package tkst_pkg;

  localparam int SCORE_W = 31;
  localparam int TAG_W   = 24;
  localparam int OP_W    = 2;
  localparam int POS_W   = 4;
  localparam int RIDX_W  = 4;
  localparam int CNT_W   = 4;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_PROBE  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_SPACE      = 8'h20;
  localparam logic [7:0] CHAR_END        = 8'h00;

  typedef struct packed {
    logic               gt;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   initials;
  } cell_link_t;

endpackage

// ===== rtl/tkst_ifs.sv =====
interface tkst_in_if;
  import tkst_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [SCORE_W-1:0] new_score;
  logic [TAG_W-1:0]   new_initials;
  logic [RIDX_W-1:0]  read_index;

  modport source (output valid, opcode, new_score, new_initials, read_index, input ready);
  modport sink   (input valid, opcode, new_score, new_initials, read_index, output ready);
endinterface

interface tkst_out_if;
  import tkst_pkg::*;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [POS_W-1:0]   position;
  logic               entry_valid;
  logic [SCORE_W-1:0] entry_score;
  logic [TAG_W-1:0]   entry_initials;
  logic [CNT_W-1:0]   entry_count;
  logic [SCORE_W-1:0] top_score;

  modport source (output valid, accepted, position, entry_valid, entry_score,
                  entry_initials, entry_count, top_score, input ready);
  modport sink   (input valid, accepted, position, entry_valid, entry_score,
                  entry_initials, entry_count, top_score, output ready);
endinterface

// ===== rtl/tkst_cell.sv =====
module tkst_cell
  import tkst_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ins_en,
  input  logic [SCORE_W-1:0] new_score,
  input  logic [TAG_W-1:0]   new_initials,
  input  cell_link_t         prev_link,
  output cell_link_t         next_link
);

  logic [SCORE_W-1:0] score_r, score_nxt;
  logic [TAG_W-1:0]   initials_r, initials_nxt;
  logic               gt;

  assign gt = new_score > score_r;

  always_comb begin
    score_nxt    = score_r;
    initials_nxt = initials_r;
    if (ins_en) begin
      if (prev_link.gt) begin
        score_nxt    = prev_link.score;
        initials_nxt = prev_link.initials;
      end else if (gt) begin
        score_nxt    = new_score;
        initials_nxt = new_initials;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r    <= '0;
      initials_r <= '0;
    end else begin
      score_r    <= score_nxt;
      initials_r <= initials_nxt;
    end
  end

  assign next_link.gt       = gt;
  assign next_link.score    = score_r;
  assign next_link.initials = initials_r;

endmodule

// ===== rtl/top_k_score_table_top.sv =====
// A result item appears in the output register in the cycle after its item is accepted.
// Throughput: one item per cycle while the output is not stalled; every cell compares and shifts in the same cycle.
// The output register is released while a new item is accepted, so stalls cost no bubbles.
// Reset: synchronous, active low; clears the table, the count and the best score.
module top_k_score_table_top
  import tkst_pkg::*;
#(
  parameter int ENTRIES = 10
) (
  input logic        clk,
  input logic        rst_n,
  tkst_in_if.sink    in_ch,
  tkst_out_if.source out_ch
);

  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW  = (IW > RIDX_W) ? IW : RIDX_W;
  localparam int CRW = (CW > RIDX_W) ? CW : RIDX_W;

  function automatic logic [TAG_W-1:0] clean_tag(input logic [TAG_W-1:0] tag);
    logic [TAG_W-1:0] res;
    logic             ended;
    logic [7:0]       ch;
    res   = '0;
    ended = 1'b0;
    for (int b = 2; b >= 0; b--) begin
      ch = tag[8*b +: 8];
      if (ch == CHAR_END) ended = 1'b1;
      if (ended) ch = CHAR_END;
      else if (ch == CHAR_UNDERSCORE) ch = CHAR_SPACE;
      res[8*b +: 8] = ch;
    end
    return res;
  endfunction

  cell_link_t         link [ENTRIES+1];
  logic               fire;
  logic               ins_en;
  logic               any_gt;
  logic [POS_W-1:0]   slot_pos;
  logic [SCORE_W-1:0] rd_score;
  logic [TAG_W-1:0]   rd_initials;
  logic               rd_ok;
  logic [TAG_W-1:0]   tag_clean;

  logic [CW-1:0]      count_r, count_nxt;
  logic [SCORE_W-1:0] best_r, best_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               acc_r, acc_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               ev_r, ev_nxt;
  logic [SCORE_W-1:0] es_r, es_nxt;
  logic [TAG_W-1:0]   et_r, et_nxt;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;
  assign tag_clean   = clean_tag(in_ch.new_initials);
  assign any_gt      = link[ENTRIES].gt;
  assign ins_en      = fire && (in_ch.opcode == OP_INSERT) && any_gt;

  assign link[0] = '{gt: 1'b0, score: '0, initials: '0};

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    tkst_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ins_en       (ins_en),
      .new_score    (in_ch.new_score),
      .new_initials (tag_clean),
      .prev_link    (link[i]),
      .next_link    (link[i+1])
    );
  end

  always_comb begin
    slot_pos    = '0;
    rd_score    = '0;
    rd_initials = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (link[i+1].gt && !link[i].gt) slot_pos = slot_pos | POS_W'(i);
      if (RW'(i) == RW'(in_ch.read_index)) begin
        rd_score    = rd_score | link[i+1].score;
        rd_initials = rd_initials | link[i+1].initials;
      end
    end
  end

  assign rd_ok = (CRW'(in_ch.read_index) < CRW'(count_r))
              && (CRW'(in_ch.read_index) < CRW'(ENTRIES));

  always_comb begin
    acc_nxt = 1'b0;
    pos_nxt = '0;
    ev_nxt  = 1'b0;
    es_nxt  = '0;
    et_nxt  = '0;
    unique case (in_ch.opcode) inside
      OP_INSERT, OP_PROBE: begin
        acc_nxt = any_gt;
        pos_nxt = any_gt ? slot_pos : '0;
      end
      OP_READ: begin
        ev_nxt = rd_ok;
        es_nxt = rd_ok ? rd_score : '0;
        et_nxt = rd_ok ? rd_initials : '0;
      end
      default: begin
        acc_nxt = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    best_nxt  = best_r;
    if (ins_en) begin
      if (count_r != CW'(ENTRIES)) count_nxt = count_r + CW'(1);
      if (in_ch.new_score > best_r) best_nxt = in_ch.new_score;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      acc_r <= acc_nxt;
      pos_r <= pos_nxt;
      ev_r  <= ev_nxt;
      es_r  <= es_nxt;
      et_r  <= et_nxt;
    end
  end

  logic [CNT_W-1:0]   cnt_out_r;
  logic [SCORE_W-1:0] top_out_r;

  always_ff @(posedge clk) begin
    if (fire) begin
      cnt_out_r <= CNT_W'(count_nxt);
      top_out_r <= best_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.accepted       = acc_r;
  assign out_ch.position       = pos_r;
  assign out_ch.entry_valid    = ev_r;
  assign out_ch.entry_score    = es_r;
  assign out_ch.entry_initials = et_r;
  assign out_ch.entry_count    = cnt_out_r;
  assign out_ch.top_score      = top_out_r;

endmodule
